// ----- rtl/sbtt_pkg.sv -----
// ----------------------------------------------------------------------------
// Sector buffer tag table package
// Shared sizes, request/result types, memory entry layout and state codes.
// ----------------------------------------------------------------------------
package sbtt_pkg;

    localparam int SLOTS    = 16;
    localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SECTOR_W = 32;
    localparam int REFS_W   = 8;
    localparam int SLOT_W   = 4;

    localparam logic [REFS_W-1:0] REFS_MAX = {REFS_W{1'b1}};
    localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(SLOTS - 1);

    typedef enum logic {
        ACT_GET     = 1'b0,
        ACT_RELEASE = 1'b1
    } t_action;

    typedef struct packed {
        t_action               action;
        logic [SECTOR_W-1:0]   sector;
    } t_request;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              hit;
        logic              full_res;
    } t_result;

    // One slot as stored in the tag memory
    typedef struct packed {
        logic [SECTOR_W-1:0] sector;
        logic [REFS_W-1:0]   refs;
    } t_entry;

    // Outcome of the scan, held until write-back
    typedef struct packed {
        logic              hit_found;
        logic [IDX_W-1:0]  hit_idx;
        logic [REFS_W-1:0] hit_refs;
        logic              free_found;
        logic [IDX_W-1:0]  free_idx;
    } t_scan;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_WRITE
    } t_state;

endpackage

// ----- rtl/sbtt_scan.sv -----
// ----------------------------------------------------------------------------
// Sector buffer tag table scan tracker
// Compares one read-back slot per cycle; keeps the first match and first free.
// ----------------------------------------------------------------------------
module sbtt_scan (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_clear,
    input  logic                          i_chk_vld,
    input  logic [sbtt_pkg::IDX_W-1:0]    i_chk_idx,
    input  logic                          i_tagged,
    input  sbtt_pkg::t_entry              i_entry,
    input  logic [sbtt_pkg::SECTOR_W-1:0] i_key,
    output sbtt_pkg::t_scan               o_scan
);

    sbtt_pkg::t_scan r_scan;
    sbtt_pkg::t_scan n_scan;
    logic            match;
    logic            is_free;

    // An untagged slot has never been claimed, so it is free whatever its stored count
    assign match   = i_chk_vld && i_tagged && (i_entry.sector == i_key);
    assign is_free = i_chk_vld && (!i_tagged || (i_entry.refs == '0));

    always_comb begin
        n_scan = r_scan;
        if (i_clear) begin
            n_scan.hit_found  = 1'b0;
            n_scan.free_found = 1'b0;
        end else begin
            if (match && !r_scan.hit_found) begin
                n_scan.hit_found = 1'b1;
                n_scan.hit_idx   = i_chk_idx;
                n_scan.hit_refs  = i_entry.refs;
            end
            if (is_free && !r_scan.free_found) begin
                n_scan.free_found = 1'b1;
                n_scan.free_idx   = i_chk_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= '0;
        end else begin
            r_scan <= n_scan;
        end
    end

    assign o_scan = r_scan;

endmodule

// ----- rtl/sector_buffer_tag_table.sv -----
// ----------------------------------------------------------------------------
// Sector buffer tag table
// Tags, reference counts and lookup for a fixed pool of sector buffers.
// ----------------------------------------------------------------------------
// Sequence: an accepted request runs ST_SCAN, the linear scan that reads one
//   slot per cycle through the tag memory read port, then ST_DRAIN, ST_WRITE.
// o_done is high in ST_WRITE. busy stays high from the accepting edge until
//   the table is back in ST_IDLE, so no new request is taken meanwhile.
// Reset: synchronous, active low; all slots become untagged at once, with no
//   clearing pass. The receiver cannot stall; results are strobed.
// ----------------------------------------------------------------------------
module sector_buffer_tag_table (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  sbtt_pkg::t_request  i_request,
    output logic                busy,
    output logic                o_done,
    output sbtt_pkg::t_result   o_result
);

    // Tag memory: sector tag and reference count per slot, registered read.
    // Contents are only meaningful where the matching tagged bit is set.
    sbtt_pkg::t_entry mem [sbtt_pkg::SLOTS];

    // Tagged bits live in flops so reset clears them all at once
    logic [sbtt_pkg::SLOTS-1:0] r_tagged;

    sbtt_pkg::t_state            r_state;
    sbtt_pkg::t_state            n_state;
    sbtt_pkg::t_request          r_req;
    logic [sbtt_pkg::IDX_W-1:0]  r_addr;
    logic [sbtt_pkg::IDX_W-1:0]  r_chk_idx;
    logic                        r_chk_vld;
    sbtt_pkg::t_entry            r_rdata;

    sbtt_pkg::t_scan             scan;
    logic                        accept;
    logic                        scan_clear;
    logic                        mem_we;
    logic [sbtt_pkg::IDX_W-1:0]  mem_waddr;
    sbtt_pkg::t_entry            mem_wdata;
    logic                        set_tag;
    logic [sbtt_pkg::REFS_W-1:0] refs_inc;
    logic                        is_get;

    assign accept = start && !busy;
    assign is_get = (r_req.action == sbtt_pkg::ACT_GET);

    // Saturating increment of the matched slot's count
    assign refs_inc = (scan.hit_refs == sbtt_pkg::REFS_MAX) ? scan.hit_refs
                                                            : scan.hit_refs + 1'b1;

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            sbtt_pkg::ST_IDLE: begin
                if (start) n_state = sbtt_pkg::ST_SCAN;
            end
            sbtt_pkg::ST_SCAN: begin
                // advance once the last slot read is issued
                if (r_addr == sbtt_pkg::IDX_LAST) n_state = sbtt_pkg::ST_DRAIN;
            end
            sbtt_pkg::ST_DRAIN: n_state = sbtt_pkg::ST_WRITE;
            sbtt_pkg::ST_WRITE: n_state = sbtt_pkg::ST_IDLE;
            default:            n_state = sbtt_pkg::ST_IDLE;
        endcase
    end

    // ---------------- outputs and write-back ----------------
    always_comb begin
        busy              = 1'b1;
        o_done            = 1'b0;
        o_result          = '0;
        scan_clear        = 1'b0;
        mem_we            = 1'b0;
        mem_waddr         = scan.hit_found ? scan.hit_idx : scan.free_idx;
        mem_wdata.sector  = r_req.sector;
        mem_wdata.refs    = '0;
        set_tag           = 1'b0;
        case (r_state)
            sbtt_pkg::ST_IDLE: begin
                busy       = 1'b0;
                scan_clear = 1'b1;
            end
            sbtt_pkg::ST_SCAN, sbtt_pkg::ST_DRAIN: begin
            end
            sbtt_pkg::ST_WRITE: begin
                o_done       = 1'b1;
                o_result.hit = scan.hit_found;
                if (scan.hit_found) begin
                    // hit: bump on get, drop to zero on release; tag stays
                    mem_we         = 1'b1;
                    mem_wdata.refs = is_get ? refs_inc : '0;
                    o_result.slot  = sbtt_pkg::SLOT_W'(scan.hit_idx);
                end else if (is_get && scan.free_found) begin
                    // miss: claim the first free slot and retag it
                    mem_we         = 1'b1;
                    set_tag        = 1'b1;
                    mem_wdata.refs = sbtt_pkg::REFS_W'(1);
                    o_result.slot  = sbtt_pkg::SLOT_W'(scan.free_idx);
                end else if (is_get) begin
                    o_result.full_res = 1'b1;
                end
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= sbtt_pkg::ST_IDLE;
            r_chk_vld <= 1'b0;
            r_tagged  <= '0;
            r_addr    <= '0;
        end else begin
            r_state   <= n_state;
            r_chk_vld <= (r_state == sbtt_pkg::ST_SCAN);
            if (r_state == sbtt_pkg::ST_SCAN) begin
                r_addr <= r_addr + 1'b1;
            end else begin
                r_addr <= '0;
            end
            if (set_tag) begin
                r_tagged[mem_waddr] <= 1'b1;
            end
        end
    end

    // Hold the request for the whole scan
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_request;
        end
        r_chk_idx <= r_addr;
    end

    // ---------------- tag memory ----------------
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[r_addr];
    end

    sbtt_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (scan_clear),
        .i_chk_vld (r_chk_vld),
        .i_chk_idx (r_chk_idx),
        .i_tagged  (r_tagged[r_chk_idx]),
        .i_entry   (r_rdata),
        .i_key     (r_req.sector),
        .o_scan    (scan)
    );

endmodule
